[hw/rtl/mjfe_pkg.sv]
// ----------------------------------------------------------------------------
// mjfe_pkg
// shared types and constants of the mjpeg frame extractor
// ----------------------------------------------------------------------------
package mjfe_pkg;

	localparam int COUNT_W = 21;
	localparam logic [COUNT_W-1:0] MAX_RESET = 21'd1048576;
	localparam int QUEUE_DEPTH_DEF = 3;

	localparam logic [7:0] MARK_LEAD = 8'hff;
	localparam logic [7:0] MARK_SOI  = 8'hd8;
	localparam logic [7:0] MARK_EOI  = 8'hd9;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
		logic       overflow;
		logic       run_last;
	} result_t;

	// up to two results written into the result queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

[hw/rtl/mjfe_result_queue.sv]
// ----------------------------------------------------------------------------
// mjfe_result_queue
// shifting result queue, takes up to two results a cycle, hands out one
// ----------------------------------------------------------------------------
module mjfe_result_queue #(
	parameter int DEPTH = mjfe_pkg::QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mjfe_pkg::push_t    push,
	input  logic               pop,
	output mjfe_pkg::result_t  head,
	output logic [CNT_W-1:0]   occupancy
);

	mjfe_pkg::result_t entry_q [DEPTH];
	mjfe_pkg::result_t entry_d [DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [CNT_W-1:0]  base;

	always_comb begin
		base = count_q - CNT_W'(pop);
		for (int i = 0; i < DEPTH; i++) begin
			entry_d[i] = entry_q[i];
			if (pop && i < DEPTH - 1) begin
				entry_d[i] = entry_q[i+1];
			end
			if (push.n != 2'd0 && CNT_W'(i) == base) begin
				entry_d[i] = push.first;
			end else if (push.n == 2'd2 && CNT_W'(i) == base + CNT_W'(1)) begin
				entry_d[i] = push.second;
			end
		end
		count_d = base + CNT_W'(push.n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			entry_q[i] <= entry_d[i];
		end
	end

	assign head      = entry_q[0];
	assign occupancy = count_q;

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue over its depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty result queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(!pop && push.n == 2'd0) |=> $stable(count_q))
		else $error("queue count moved without push or pop");

endmodule

[hw/rtl/mjpeg_frame_extractor.sv]
// ----------------------------------------------------------------------------
// mjpeg_frame_extractor
// cuts jpeg frames (ff d8 .. ff d9) out of a raw mjpeg byte stream
// ----------------------------------------------------------------------------
// The slave channel takes one raw stream byte per transaction in
// s_axis_tdata. The master channel gives the frame bytes: tuser flags the
// closing d9 (frame end) or an aborted frame (overflow), tlast marks the last
// result caused by one input byte. Bytes outside a frame give no result; the
// start marker gives two results, ff then d8.
// cfg_wr_en/cfg_wr_data set the frame length limit; the user writes it only
// while idle, the block itself does not enforce this. An accepted byte
// passes the input register, then the result queue, to the master side.
// Throughput: one byte per cycle while the result queue has room; a start
// marker gives an extra result, absorbed by the queue of QUEUE_DEPTH entries.
// A byte waiting in the input register moves on when the queue has room
// for all its results, so s_axis_tready never depends on m_axis_tready
// in the same cycle; when the receiver stalls the queue fills and then the
// input stalls.
// Reset clears the scan state, the byte count and the queue, and sets the
// limit to 1048576 bytes.
// ----------------------------------------------------------------------------
module mjpeg_frame_extractor #(
	parameter int QUEUE_DEPTH = mjfe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mjfe_pkg::COUNT_W-1:0] cfg_wr_data,  // max_frame_bytes
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // [7:0] stream_byte
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [7:0]                   m_axis_tdata,  // [7:0] frame_byte
	output logic [1:0]                   m_axis_tuser,  // [0] frame_end, [1] overflow
	output logic                         m_axis_tlast   // run_last
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int COUNT_W = mjfe_pkg::COUNT_W;

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HUNT_FF = 2'd1;
	localparam logic [1:0] PH_DATA    = 2'd2;
	localparam logic [1:0] PH_DATA_FF = 2'd3;

	logic               in_valid_s1;
	logic [7:0]         in_byte_s1;
	logic [1:0]         phase_q;
	logic [COUNT_W-1:0] frame_cnt_q;
	logic [COUNT_W-1:0] max_q;

	logic [1:0]         phase_d;
	logic [COUNT_W-1:0] frame_cnt_d;
	logic [COUNT_W-1:0] cnt_inc;
	mjfe_pkg::push_t    step;
	mjfe_pkg::push_t    push;
	mjfe_pkg::result_t  head;
	logic [CNT_W-1:0]   occupancy;
	logic [CNT_W-1:0]   free_slots;
	logic               advance;

	always_comb begin
		phase_d     = phase_q;
		frame_cnt_d = frame_cnt_q;
		cnt_inc     = frame_cnt_q + COUNT_W'(1);
		step.n      = 2'd0;
		step.first  = '{frame_byte: in_byte_s1, frame_end: 1'b0, overflow: 1'b0,
			run_last: 1'b1};
		step.second = '{frame_byte: mjfe_pkg::MARK_SOI, frame_end: 1'b0,
			overflow: 1'b0, run_last: 1'b1};
		case (phase_q)
			PH_HUNT: begin
				if (in_byte_s1 == mjfe_pkg::MARK_LEAD) begin
					phase_d = PH_HUNT_FF;
				end
			end
			PH_HUNT_FF: begin
				// a second ff falls back to plain hunting
				if (in_byte_s1 == mjfe_pkg::MARK_SOI) begin
					phase_d                  = PH_DATA;
					frame_cnt_d              = COUNT_W'(2);
					step.n                   = 2'd2;
					step.first.frame_byte    = mjfe_pkg::MARK_LEAD;
					step.first.run_last      = 1'b0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				step.n      = 2'd1;
				frame_cnt_d = cnt_inc;
				if (cnt_inc >= max_q) begin
					phase_d             = PH_HUNT;
					frame_cnt_d         = '0;
					step.first.overflow = 1'b1;
				end else if (phase_q == PH_DATA_FF) begin
					if (in_byte_s1 == mjfe_pkg::MARK_EOI) begin
						phase_d              = PH_HUNT;
						frame_cnt_d          = '0;
						step.first.frame_end = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end else if (in_byte_s1 == mjfe_pkg::MARK_LEAD) begin
					phase_d = PH_DATA_FF;
				end
			end
		endcase
	end

	assign free_slots    = CNT_W'(QUEUE_DEPTH) - occupancy;
	assign advance       = in_valid_s1 && (free_slots >= CNT_W'(step.n));
	assign s_axis_tready = !in_valid_s1 || advance;

	always_comb begin
		push   = step;
		if (!advance) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			phase_q     <= PH_HUNT;
			frame_cnt_q <= '0;
			max_q       <= mjfe_pkg::MAX_RESET;
		end else begin
			if (s_axis_tready) begin
				in_valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				phase_q     <= phase_d;
				frame_cnt_q <= frame_cnt_d;
			end
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	mjfe_result_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_axis_tvalid && m_axis_tready),
		.head      (head),
		.occupancy (occupancy)
	);

	assign m_axis_tvalid = occupancy != '0;
	assign m_axis_tdata  = head.frame_byte;
	assign m_axis_tuser  = {head.overflow, head.frame_end};
	assign m_axis_tlast  = head.run_last;

	a_hunt_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT || phase_q == PH_HUNT_FF) |-> frame_cnt_q == '0)
		else $error("byte count not zero while hunting");

	a_soi_enters_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |=> (phase_q == PH_DATA && frame_cnt_q == COUNT_W'(2)))
		else $error("start marker did not open a frame");

	a_close_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0 && (push.first.frame_end || push.first.overflow))
		|=> (phase_q == PH_HUNT && frame_cnt_q == '0))
		else $error("frame close did not return to hunting");

	a_no_result_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_HUNT) |-> push.n == 2'd0)
		else $error("result produced while hunting");

endmodule
